/* hw/rtl/sdq_pkg.sv */
// Shared types and constants for the sleep delta queue timer.
// No dependencies; imported by sdq_out_stage and sleep_delta_queue_timer.
package sdq_pkg;

  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int MAX_WAKE        = 16;
  localparam int DELAY_W         = 32;
  localparam int ID_W            = 8;
  localparam int STATUS_W        = 2;

  // Input item kinds
  localparam logic MODE_TICK  = 1'b0;
  localparam logic MODE_SLEEP = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_WOKEN  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ACCEPT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_REJECT = 2'd2;

  // One queue entry as kept in memory
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [DELAY_W-1:0] delay;
  } sdq_entry_t;

  // One result item
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     id;
    logic                last;
  } sdq_res_t;

endpackage

/* hw/rtl/sdq_out_stage.sv */
// Output register for result items: holds one item until the sink takes it.
// Depends on sdq_pkg.
module sdq_out_stage (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      load,
  input  sdq_pkg::sdq_res_t         res,
  output logic                      free,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [sdq_pkg::ID_W-1:0]  out_tdata,  // [7:0] woken_id
  output logic [sdq_pkg::STATUS_W-1:0] out_tuser, // [1:0] status
  output logic                      out_tlast   // last
);
  import sdq_pkg::*;

  logic     valid_r;
  sdq_res_t res_r;

  // Track occupancy of the slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  // Capture the item payload
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign free       = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tdata  = res_r.id;
  assign out_tuser  = res_r.status;
  assign out_tlast  = res_r.last;

endmodule

/* hw/rtl/sleep_delta_queue_timer.sv */
// Delta-list queue of sleeping threads held in a circular buffer memory.
// Depends on sdq_pkg and sdq_out_stage.
//
//  Channel | Ports                      | Item
//  --------+----------------------------+-------------------------------------
//  input   | in_tvalid/tready/tdata/tuser | tick or sleep request
//  result  | out_tvalid/tready/tdata/tuser/tlast | woken / accepted / rejected
//
// One item at a time; the entry memory (one read and one write port, registered
// read data) sets the pace. A tick on an empty queue does nothing; one with a
// nonzero head counts that head down. A tick whose head is zero wakes threads
// until the queue empties, the wake limit is reached or a nonzero head ends the
// burst. A sleep walks past entries, then shifts later ones back and inserts, or
// appends after the last entry; a sleep on a full queue is rejected.
// Synchronous active-low reset empties the queue; no clearing pass.
// A busy output register stalls result emission and, in a wake burst, the dequeue of the next woken thread.
module sleep_delta_queue_timer #(
  parameter int QUEUE_DEPTH = sdq_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       in_tvalid,
  output logic                                       in_tready,
  input  logic [sdq_pkg::ID_W+sdq_pkg::DELAY_W-1:0]  in_tdata,  // [7:0] thread_id, [39:8] sleep_ticks
  input  logic                                       in_tuser,  // mode
  output logic                                       out_tvalid,
  input  logic                                       out_tready,
  output logic [sdq_pkg::ID_W-1:0]                   out_tdata, // [7:0] woken_id
  output logic [sdq_pkg::STATUS_W-1:0]               out_tuser, // [1:0] status
  output logic                                       out_tlast  // last
);
  import sdq_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int NW = $clog2(MAX_WAKE + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SRD  = 4'd1;
  localparam logic [3:0] S_SCMP = 4'd2;
  localparam logic [3:0] S_HRD  = 4'd3;
  localparam logic [3:0] S_HWR  = 4'd4;
  localparam logic [3:0] S_WFOL = 4'd5;
  localparam logic [3:0] S_WNEW = 4'd6;
  localparam logic [3:0] S_TRD  = 4'd7;
  localparam logic [3:0] S_TCHK = 4'd8;
  localparam logic [3:0] S_EMIT = 4'd9;

  // Map a queue position to a memory address
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                         input logic [AW-1:0] k);
    logic [AW:0] s;
    s = {1'b0, head} + {1'b0, k};
    if (s >= (AW+1)'(QUEUE_DEPTH)) begin
      s = s - (AW+1)'(QUEUE_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  // Control registers
  logic [3:0]          state_r, state_nxt;
  logic [AW-1:0]       head_r, head_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [AW-1:0]       pos_r, pos_nxt;
  logic [AW-1:0]       idx_r, idx_nxt;
  logic [NW-1:0]       wake_n_r, wake_n_nxt;

  // Payload registers
  logic [ID_W-1:0]     tid_r, tid_nxt;
  logic [DELAY_W-1:0]  ticks_r, ticks_nxt;
  logic [DELAY_W-1:0]  sum_r, sum_nxt;
  sdq_entry_t          fol_r, fol_nxt;
  logic [ID_W-1:0]     pend_id_r, pend_id_nxt;
  logic [STATUS_W-1:0] pend_st_r, pend_st_nxt;

  // Entry memory
  sdq_entry_t          mem [QUEUE_DEPTH];
  sdq_entry_t          rd_r;
  logic                mem_we, mem_re;
  logic [AW-1:0]       mem_wa, mem_ra;
  sdq_entry_t          mem_wd;

  // Output side
  logic                out_load, out_free;
  sdq_res_t            out_res;

  logic [DELAY_W:0]    sum_ext;
  logic                walk_on;
  logic [DELAY_W-1:0]  rel;
  logic [AW-1:0]       head_adv;

  assign sum_ext  = {1'b0, sum_r} + {1'b0, rd_r.delay};
  assign walk_on  = {1'b0, ticks_r} > sum_ext;
  assign rel      = ticks_r - sum_r;
  assign head_adv = (head_r == AW'(QUEUE_DEPTH - 1)) ? '0 : head_r + AW'(1);
  assign in_tready = (state_r == S_IDLE);

  // Sequencer: walk, shift, insert, wake, count down the head, reject, emit
  always_comb begin
    state_nxt   = state_r;
    head_nxt    = head_r;
    cnt_nxt     = cnt_r;
    pos_nxt     = pos_r;
    idx_nxt     = idx_r;
    wake_n_nxt  = wake_n_r;
    tid_nxt     = tid_r;
    ticks_nxt   = ticks_r;
    sum_nxt     = sum_r;
    fol_nxt     = fol_r;
    pend_id_nxt = pend_id_r;
    pend_st_nxt = pend_st_r;
    mem_we      = 1'b0;
    mem_wa      = '0;
    mem_wd      = '0;
    mem_re      = 1'b0;
    mem_ra      = '0;
    out_load    = 1'b0;
    out_res     = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          tid_nxt    = in_tdata[ID_W-1:0];
          ticks_nxt  = in_tdata[ID_W+DELAY_W-1:ID_W];
          sum_nxt    = '0;
          pos_nxt    = '0;
          wake_n_nxt = '0;
          if (in_tuser == MODE_SLEEP) begin
            if (cnt_r == CW'(QUEUE_DEPTH)) begin
              pend_id_nxt = in_tdata[ID_W-1:0];
              pend_st_nxt = ST_REJECT;
              state_nxt   = S_EMIT;
            end else if (cnt_r == '0) begin
              state_nxt = S_WNEW;
            end else begin
              state_nxt = S_SRD;
            end
          end else begin
            pend_st_nxt = ST_WOKEN;
            if (cnt_r != '0) begin
              state_nxt = S_TRD;
            end
          end
        end
      end
      S_SRD: begin
        mem_re    = 1'b1;
        mem_ra    = phys(head_r, pos_r);
        state_nxt = S_SCMP;
      end
      S_SCMP: begin
        if (walk_on) begin
          // Step past this entry
          sum_nxt = sum_ext[DELAY_W-1:0];
          pos_nxt = pos_r + AW'(1);
          if (CW'(pos_r) + CW'(1) == cnt_r) begin
            state_nxt = S_WNEW;
          end else begin
            state_nxt = S_SRD;
          end
        end else begin
          // Found the slot; the entry here moves back with reduced delay
          fol_nxt.id    = rd_r.id;
          fol_nxt.delay = rd_r.delay - rel;
          idx_nxt       = AW'(cnt_r);
          if (cnt_r > CW'(pos_r) + CW'(1)) begin
            state_nxt = S_HRD;
          end else begin
            state_nxt = S_WFOL;
          end
        end
      end
      S_HRD: begin
        mem_re    = 1'b1;
        mem_ra    = phys(head_r, idx_r - AW'(1));
        state_nxt = S_HWR;
      end
      S_HWR: begin
        mem_we  = 1'b1;
        mem_wa  = phys(head_r, idx_r);
        mem_wd  = rd_r;
        idx_nxt = idx_r - AW'(1);
        if ({1'b0, idx_r} - (AW+1)'(1) > {1'b0, pos_r} + (AW+1)'(1)) begin
          state_nxt = S_HRD;
        end else begin
          state_nxt = S_WFOL;
        end
      end
      S_WFOL: begin
        mem_we    = 1'b1;
        mem_wa    = phys(head_r, pos_r + AW'(1));
        mem_wd    = fol_r;
        state_nxt = S_WNEW;
      end
      S_WNEW: begin
        mem_we       = 1'b1;
        mem_wa       = phys(head_r, pos_r);
        mem_wd.id    = tid_r;
        mem_wd.delay = rel;
        cnt_nxt      = cnt_r + CW'(1);
        pend_id_nxt  = tid_r;
        pend_st_nxt  = ST_ACCEPT;
        state_nxt    = S_EMIT;
      end
      S_TRD: begin
        mem_re    = 1'b1;
        mem_ra    = head_r;
        state_nxt = S_TCHK;
      end
      S_TCHK: begin
        if (wake_n_r == '0) begin
          if (rd_r.delay != '0) begin
            // Count down the head
            mem_we       = 1'b1;
            mem_wa       = head_r;
            mem_wd.id    = rd_r.id;
            mem_wd.delay = rd_r.delay - DELAY_W'(1);
            state_nxt    = S_IDLE;
          end else begin
            pend_id_nxt = rd_r.id;
            head_nxt    = head_adv;
            cnt_nxt     = cnt_r - CW'(1);
            wake_n_nxt  = NW'(1);
            if (cnt_r == CW'(1) || NW'(MAX_WAKE) == NW'(1)) begin
              state_nxt = S_EMIT;
            end else begin
              state_nxt = S_TRD;
            end
          end
        end else if (rd_r.delay == '0) begin
          // Another zero head: release the held thread as not last
          if (out_free) begin
            out_load       = 1'b1;
            out_res.status = ST_WOKEN;
            out_res.id     = pend_id_r;
            out_res.last   = 1'b0;
            pend_id_nxt    = rd_r.id;
            head_nxt       = head_adv;
            cnt_nxt        = cnt_r - CW'(1);
            wake_n_nxt     = wake_n_r + NW'(1);
            if (cnt_r == CW'(1) || wake_n_r + NW'(1) == NW'(MAX_WAKE)) begin
              state_nxt = S_EMIT;
            end else begin
              state_nxt = S_TRD;
            end
          end
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_res.status = pend_st_r;
          out_res.id     = pend_id_r;
          out_res.last   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      head_r   <= '0;
      cnt_r    <= '0;
      pos_r    <= '0;
      idx_r    <= '0;
      wake_n_r <= '0;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      cnt_r    <= cnt_nxt;
      pos_r    <= pos_nxt;
      idx_r    <= idx_nxt;
      wake_n_r <= wake_n_nxt;
    end
  end

  // Payload state
  always_ff @(posedge clk) begin
    tid_r     <= tid_nxt;
    ticks_r   <= ticks_nxt;
    sum_r     <= sum_nxt;
    fol_r     <= fol_nxt;
    pend_id_r <= pend_id_nxt;
    pend_st_r <= pend_st_nxt;
  end

  // Entry memory, registered read; read data holds while no read is issued
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_r <= mem[mem_ra];
    end
  end

  sdq_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (out_load),
    .res        (out_res),
    .free       (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Occupancy never exceeds the queue depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(QUEUE_DEPTH))
    else $error("queue occupancy above depth");

  // Sequencing keeps a read and a write off the same entry in one cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re && mem_wa == mem_ra))
    else $error("read and write to the same entry in one cycle");

  // Wake count per tick stays within the limit
  a_wake_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wake_n_r <= NW'(MAX_WAKE))
    else $error("too many threads woken by one tick");

  // The walk only compares occupied entries
  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCMP |-> CW'(pos_r) < cnt_r)
    else $error("sorted walk beyond occupied entries");

  // A result is never loaded over one the sink has not taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_tvalid || out_tready))
    else $error("result overwritten before it was taken");

endmodule
